/* src/assert_macros.svh */
// Assertion macros shared by the RTL. In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge while reset is released.
`define HPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define HPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define HPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/hpt_pkg.sv */
package hpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WORD_W      = 32;
    localparam int TOTAL_W     = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORDS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = CFG_IDX_W'(1);

    localparam logic [WORD_W-1:0] MIN_WORDS_RESET = WORD_W'(256);
    localparam logic [WORD_W-1:0] COOLDOWN_RESET  = WORD_W'(180);

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_DECIDE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_INGEST = 2'd0,
        CMD_DECIDE = 2'd1,
        CMD_ACK    = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0]  pc;
        logic [TOTAL_W-1:0] total;
        logic [WORD_W-1:0]  seen;
        logic [WORD_W-1:0]  refresh;
    } t_entry;

    // Sweep control from the sequencer to the scan unit.
    typedef struct packed {
        logic             start;
        logic             rd_vld;
        logic [IDX_W-1:0] rd_idx;
        logic             entry_valid;
    } t_scan_ctl;

    // Outcome of one sweep over the table.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        t_entry            entry;
        logic [WORD_W-1:0] best_w;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } t_scan_res;

endpackage

/* src/hpt_in_if.sv */
interface hpt_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [hpt_pkg::WORD_W-1:0]   pc_value;
    logic [hpt_pkg::WORD_W-1:0]   word_count;
    logic [hpt_pkg::WORD_W-1:0]   frame;
    logic                         end_of_summary;

    modport source (
        output valid, command, pc_value, word_count, frame, end_of_summary,
        input  ready
    );
    modport sink (
        input  valid, command, pc_value, word_count, frame, end_of_summary,
        output ready
    );
endinterface

/* src/hpt_out_if.sv */
interface hpt_out_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic                       changed;
    logic                       dropped;
    logic                       request;
    logic [hpt_pkg::WORD_W-1:0] hot_pc;
    logic [hpt_pkg::WORD_W-1:0] hot_weight;

    modport source (
        output valid, kind, changed, dropped, request, hot_pc, hot_weight,
        input  ready
    );
    modport sink (
        input  valid, kind, changed, dropped, request, hot_pc, hot_weight,
        output ready
    );
endinterface

/* src/hotspot_pc_tracker.sv */
// Hotspot PC tracker. The block keeps a table of TABLE_DEPTH program-counter
// entries in one single-port-read, single-port-write RAM (PC, 64-bit word
// total, last seen frame, last refresh frame per row), with the per-row valid
// bits in flip-flops so that reset and the clear command empty the table at
// once. Ingest, decide and acknowledge items each sweep the whole table
// through the RAM read port, one row per cycle, and then write back at most
// one row before the block can accept the next item; a clear item leaves
// the block idle. Only one item is in flight at a time, so a write-back
// always lands before the next sweep begins and no forwarding is needed.
// Results sit in an output register: the next item is accepted while a result
// still waits, and an item that produces a result holds in its last step only
// when the previous result has not yet been taken. Configuration registers
// (min_words at index 0, cooldown_frames at index 1) are written through a
// plain write port; the user must write them only while the block is idle,
// which the block itself does not enforce; other indexes are ignored.
`include "assert_macros.svh"

module hotspot_pc_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hpt_in_if.sink                          i_item,
    hpt_out_if.source                       o_result,
    input  logic                            i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hpt_pkg::WORD_W-1:0]      i_cfg_data
);

    localparam int IDX_W  = hpt_pkg::IDX_W;
    localparam int CNT_W  = hpt_pkg::CNT_W;
    localparam int WORD_W = hpt_pkg::WORD_W;

    // Sequencer state.
    hpt_pkg::t_state              r_state;
    hpt_pkg::t_state              n_state;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_rd_vld;
    logic [IDX_W-1:0]             r_rd_idx;
    logic [hpt_pkg::TABLE_DEPTH-1:0] r_valid;

    // Configuration and summary flags.
    logic [WORD_W-1:0]            r_min_words;
    logic [WORD_W-1:0]            r_cooldown;
    logic                         r_chg;
    logic                         r_drp;

    // The item under work.
    hpt_pkg::t_cmd                r_cmd;
    logic [WORD_W-1:0]            r_pc;
    logic [WORD_W-1:0]            r_words;
    logic [WORD_W-1:0]            r_frame;
    logic                         r_last;

    // Output register.
    logic                         r_out_vld;
    logic                         r_out_kind;
    logic                         r_out_chg;
    logic                         r_out_drp;
    logic                         r_out_req;
    logic [WORD_W-1:0]            r_out_pc;
    logic [WORD_W-1:0]            r_out_wt;

    // Table access and finishing logic.
    hpt_pkg::t_scan_ctl           scan_ctl;
    hpt_pkg::t_scan_res           scan_res;
    hpt_pkg::t_entry              rd_entry;
    hpt_pkg::t_entry              base_entry;
    hpt_pkg::t_entry              wr_entry;
    logic [IDX_W-1:0]             wr_idx;
    logic                         wr_want;
    logic                         ram_we;
    logic                         alloc;
    logic                         has_res;
    logic                         req;
    logic                         chg_now;
    logic                         drp_now;
    logic                         fin_go;
    logic                         in_acc;
    logic                         out_free;
    logic                         scan_busy;
    hpt_pkg::t_cmd                in_cmd;

    assign in_cmd   = hpt_pkg::t_cmd'(i_item.command);
    assign in_acc   = i_item.valid && i_item.ready;
    assign out_free = !r_out_vld || o_result.ready;
    assign scan_busy = (r_state == hpt_pkg::ST_SCAN)
                       && (r_cnt < CNT_W'(hpt_pkg::TABLE_DEPTH));

    hpt_ram #(
        .WIDTH ($bits(hpt_pkg::t_entry)),
        .DEPTH (hpt_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (wr_entry),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (rd_entry)
    );

    hpt_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_rdata     (rd_entry),
        .i_cmd       (r_cmd),
        .i_pc        (r_pc),
        .i_frame     (r_frame),
        .i_min_words (r_min_words),
        .i_cooldown  (r_cooldown),
        .o_res       (scan_res)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpt_pkg::ST_IDLE: begin
                if (in_acc && (in_cmd != hpt_pkg::CMD_CLEAR)) begin
                    n_state = hpt_pkg::ST_SCAN;
                end
            end
            hpt_pkg::ST_SCAN: begin
                if (r_cnt == CNT_W'(hpt_pkg::TABLE_DEPTH)) begin
                    n_state = hpt_pkg::ST_FINISH;
                end
            end
            hpt_pkg::ST_FINISH: begin
                if (fin_go) begin
                    n_state = hpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer and the write-back of the finishing step.
    always_comb begin
        i_item.ready         = (r_state == hpt_pkg::ST_IDLE);
        scan_ctl.start       = in_acc;
        scan_ctl.rd_vld      = r_rd_vld;
        scan_ctl.rd_idx      = r_rd_idx;
        scan_ctl.entry_valid = r_valid[r_rd_idx];

        // A new entry starts from zero totals and frames.
        base_entry = scan_res.entry;
        if (!scan_res.found) begin
            base_entry.pc      = r_pc;
            base_entry.total   = '0;
            base_entry.seen    = '0;
            base_entry.refresh = '0;
        end

        wr_entry = scan_res.entry;
        wr_idx   = scan_res.idx;
        wr_want  = 1'b0;
        alloc    = 1'b0;
        has_res  = 1'b0;
        req      = 1'b0;
        chg_now  = 1'b0;
        drp_now  = 1'b0;

        unique case (r_cmd)
            hpt_pkg::CMD_INGEST: begin
                has_res = r_last;
                if (scan_res.found || scan_res.free_found) begin
                    wr_want        = 1'b1;
                    alloc          = !scan_res.found;
                    wr_idx         = scan_res.found ? scan_res.idx : scan_res.free_idx;
                    wr_entry       = base_entry;
                    wr_entry.total = base_entry.total
                                     + {{(hpt_pkg::TOTAL_W - WORD_W){1'b0}}, r_words};
                    wr_entry.seen  = r_frame;
                    chg_now        = (r_words != '0) || (r_frame != base_entry.seen);
                end else begin
                    drp_now = 1'b1;
                end
            end
            hpt_pkg::CMD_DECIDE: begin
                has_res          = 1'b1;
                req              = scan_res.found && (scan_res.entry.pc != '0);
                wr_want          = req;
                wr_entry.refresh = r_frame;
            end
            hpt_pkg::CMD_ACK: begin
                wr_want          = scan_res.found && (r_pc != '0);
                wr_entry.refresh = r_frame;
            end
            hpt_pkg::CMD_CLEAR: begin
                wr_want = 1'b0;
            end
            default: begin
                wr_want = 1'b0;
            end
        endcase

        fin_go = (r_state == hpt_pkg::ST_FINISH) && (!has_res || out_free);
        ram_we = wr_want && fin_go;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpt_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_valid     <= '0;
            r_min_words <= hpt_pkg::MIN_WORDS_RESET;
            r_cooldown  <= hpt_pkg::COOLDOWN_RESET;
            r_chg       <= 1'b0;
            r_drp       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= scan_busy;

            if (i_cfg_we) begin
                if (i_cfg_idx == hpt_pkg::CFG_MIN_WORDS) begin
                    r_min_words <= i_cfg_data;
                end else if (i_cfg_idx == hpt_pkg::CFG_COOLDOWN) begin
                    r_cooldown <= i_cfg_data;
                end
            end

            if (in_acc) begin
                r_cnt <= '0;
                if (in_cmd == hpt_pkg::CMD_CLEAR) begin
                    r_valid <= '0;
                end
            end else if (scan_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            // A new result replaces the one being taken in the same cycle.
            if (fin_go && has_res) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end

            if (fin_go) begin
                if (alloc) begin
                    r_valid[wr_idx] <= 1'b1;
                end
                if (r_cmd == hpt_pkg::CMD_INGEST) begin
                    // The last item of a summary reports and restarts the flags.
                    if (r_last) begin
                        r_chg <= 1'b0;
                        r_drp <= 1'b0;
                    end else begin
                        r_chg <= r_chg | chg_now;
                        r_drp <= r_drp | drp_now;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_cnt[IDX_W-1:0];
        if (in_acc) begin
            r_cmd   <= in_cmd;
            r_pc    <= i_item.pc_value;
            r_words <= i_item.word_count;
            r_frame <= i_item.frame;
            r_last  <= i_item.end_of_summary;
        end
        if (fin_go && has_res) begin
            if (r_cmd == hpt_pkg::CMD_DECIDE) begin
                r_out_kind <= hpt_pkg::KIND_DECIDE;
                r_out_chg  <= 1'b0;
                r_out_drp  <= 1'b0;
            end else begin
                r_out_kind <= hpt_pkg::KIND_SUMMARY;
                r_out_chg  <= r_chg | chg_now;
                r_out_drp  <= r_drp | drp_now;
            end
            r_out_req <= req;
            r_out_pc  <= req ? scan_res.entry.pc : '0;
            r_out_wt  <= req ? scan_res.best_w : '0;
        end
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.kind       = r_out_kind;
    assign o_result.changed    = r_out_chg;
    assign o_result.dropped    = r_out_drp;
    assign o_result.request    = r_out_req;
    assign o_result.hot_pc     = r_out_pc;
    assign o_result.hot_weight = r_out_wt;

    // The table is written only in the finishing step of an item.
    `HPT_ASSERT(a_we_in_finish, i_clk, i_rst_n,
        !ram_we || (r_state == hpt_pkg::ST_FINISH),
        "table written outside finish step")

    // A sweep starts from row zero right after an item that needs it.
    `HPT_ASSERT_NEXT(a_sweep_start, i_clk, i_rst_n,
        in_acc && (in_cmd != hpt_pkg::CMD_CLEAR),
        (r_state == hpt_pkg::ST_SCAN) && (r_cnt == '0),
        "sweep did not start at row zero")

    // The sweep counter stops at the table depth.
    `HPT_ASSERT(a_cnt_bound, i_clk, i_rst_n,
        (r_state != hpt_pkg::ST_SCAN) || (r_cnt <= CNT_W'(hpt_pkg::TABLE_DEPTH)),
        "sweep counter ran past the table")

    // A new entry is placed only into an empty row.
    `HPT_ASSERT(a_alloc_free, i_clk, i_rst_n,
        !(ram_we && alloc) || !r_valid[wr_idx],
        "allocation over a valid row")

endmodule

/* src/hpt_ram.sv */
module hpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/hpt_scan.sv */
module hpt_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hpt_pkg::t_scan_ctl          i_ctl,
    input  hpt_pkg::t_entry             i_rdata,
    input  hpt_pkg::t_cmd               i_cmd,
    input  logic [hpt_pkg::WORD_W-1:0]  i_pc,
    input  logic [hpt_pkg::WORD_W-1:0]  i_frame,
    input  logic [hpt_pkg::WORD_W-1:0]  i_min_words,
    input  logic [hpt_pkg::WORD_W-1:0]  i_cooldown,
    output hpt_pkg::t_scan_res          o_res
);

    hpt_pkg::t_scan_res          r_res;
    logic [hpt_pkg::WORD_W-1:0]  weight;
    logic                        cooling;
    logic                        eligible;
    logic                        better;
    logic                        match;

    always_comb begin
        // Totals beyond 32 bits saturate.
        weight   = (|i_rdata.total[hpt_pkg::TOTAL_W-1:hpt_pkg::WORD_W])
                   ? '1 : i_rdata.total[hpt_pkg::WORD_W-1:0];
        cooling  = (i_frame > i_rdata.refresh)
                   && ((i_frame - i_rdata.refresh) < i_cooldown);
        eligible = i_ctl.entry_valid && (i_rdata.seen == i_frame)
                   && (weight >= i_min_words) && (weight != '0) && !cooling;
        better   = !r_res.found || (weight > r_res.best_w)
                   || ((weight == r_res.best_w) && (i_rdata.pc < r_res.entry.pc));
        match    = i_ctl.entry_valid && (i_rdata.pc == i_pc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.found      <= 1'b0;
            r_res.free_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_res.found      <= 1'b0;
            r_res.free_found <= 1'b0;
        end else if (i_ctl.rd_vld) begin
            if (i_cmd == hpt_pkg::CMD_DECIDE) begin
                if (eligible && better) begin
                    r_res.found  <= 1'b1;
                    r_res.idx    <= i_ctl.rd_idx;
                    r_res.entry  <= i_rdata;
                    r_res.best_w <= weight;
                end
            end else begin
                if (match) begin
                    r_res.found <= 1'b1;
                    r_res.idx   <= i_ctl.rd_idx;
                    r_res.entry <= i_rdata;
                end
                if (!i_ctl.entry_valid && !r_res.free_found) begin
                    r_res.free_found <= 1'b1;
                    r_res.free_idx   <= i_ctl.rd_idx;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule
